>>> design/supply_voltage_source_detector_unit_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the supply voltage source detector
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SUPPLY_VOLTAGE_SOURCE_DETECTOR_UNIT_ASSERT_SVH
`define SUPPLY_VOLTAGE_SOURCE_DETECTOR_UNIT_ASSERT_SVH

// property that holds at every edge
`define SVSD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("svsd assertion failed");

// same-cycle implication
`define SVSD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("svsd assertion failed");

// next-cycle implication
`define SVSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("svsd assertion failed");

`endif

>>> design/svsd_pkg.sv
// ----------------------------------------------------------------------------
// svsd_pkg
// shared types and constants of the supply voltage source detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svsd_pkg;

  localparam int unsigned MvW   = 16;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned TminW = 5;

  typedef enum logic [1:0] {
    CFG_DROP_THRESHOLD  = 2'd0,
    CFG_RISE_THRESHOLD  = 2'd1,
    CFG_TREND_THRESHOLD = 2'd2,
    CFG_TREND_MIN       = 2'd3
  } cfg_idx_e;

  localparam logic [CfgW-1:0]  DropThresholdRst  = 16'd300;
  localparam logic [CfgW-1:0]  RiseThresholdRst  = 16'd300;
  localparam logic [CfgW-1:0]  TrendThresholdRst = 16'd200;
  localparam logic [TminW-1:0] TrendMinRst       = 5'd8;

  // readings needed before the jump test, smallest drift minimum
  localparam int unsigned JumpMinFill  = 4;
  localparam int unsigned TrendMinLow  = 3;

  // result of one item
  typedef struct packed {
    logic on_external_power;
    logic source_changed;
  } res_t;

endpackage

>>> design/supply_voltage_source_detector_unit.sv
// ----------------------------------------------------------------------------
// supply_voltage_source_detector_unit
// tracks external power versus battery from a stream of supply readings
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: reading_mv, tuser: req_type
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: source_changed, on_external_power
// cfg       in   cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// one item per cycle while the skid stage is empty; its result is registered in the result buffer
// the window, jump and drift tests are done in the accept cycle
// a two-entry result buffer keeps input open while one result waits
// reset empties the window and assumes external power
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module supply_voltage_source_detector_unit import svsd_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,   // [15:0] reading_mv
  input  logic             s_axis_tuser,   // [0] req_type
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [0] source_changed, [1] on_external_power
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_wdata_i
);

  localparam int unsigned FillW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CmpW  = (FillW > TminW) ? FillW : TminW;
  localparam int unsigned Taps  = WINDOW_DEPTH - 3;

  logic [CfgW-1:0]  drop_th_q, rise_th_q, trend_th_q;
  logic [TminW-1:0] trend_min_q;

  logic [FillW-1:0] fill_q, fill_d;
  logic             flag_q, flag_d;
  logic [MvW-1:0]   tap_q [Taps];
  logic [MvW-1:0]   oldest_q [3];
  logic [MvW-1:0]   oldest_d [3];

  logic             s_acc;
  logic             is_reading;
  logic [MvW-1:0]   mv;
  logic             full;
  logic [CmpW-1:0]  fill_after;
  logic [TminW-1:0] need;
  logic             jump_en, drift_en;
  logic [MvW:0]     pair_sum;
  logic [MvW+1:0]   new_sum, old_sum;
  logic [MvW-1:0]   new_avg, old_avg;
  logic signed [MvW+1:0] jump, drift;
  logic             flag_mid;
  res_t             res;
  logic             buf_ready;
  res_t             out_res;

  function automatic logic [MvW-1:0] div3(input logic [MvW+1:0] x);
    logic [2*MvW+3:0] p;
    p = x * 18'd174763;
    return p[MvW+18:19];
  endfunction

  function automatic logic apply_test(input logic f, input logic signed [MvW+1:0] v,
                                      input logic [CfgW-1:0] fall,
                                      input logic [CfgW-1:0] rise);
    logic signed [MvW+1:0] lo, hi;
    lo = -$signed({2'b00, fall});
    hi = $signed({2'b00, rise});
    priority if (f && v <= lo) begin
      return 1'b0;
    end else if (!f && v >= hi) begin
      return 1'b1;
    end else begin
      return f;
    end
  endfunction

  assign s_axis_tready = buf_ready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign is_reading    = !s_axis_tuser;
  assign mv            = s_axis_tdata;
  assign full          = (fill_q == FillW'(WINDOW_DEPTH));

  // window bookkeeping
  always_comb begin
    fill_after = full ? CmpW'(WINDOW_DEPTH) : CmpW'(fill_q) + CmpW'(1);
    for (int i = 0; i < 3; i++) begin
      oldest_d[i] = oldest_q[i];
    end
    if (full) begin
      oldest_d[0] = oldest_q[1];
      oldest_d[1] = oldest_q[2];
      oldest_d[2] = tap_q[Taps-1];
    end else if (CmpW'(fill_q) < CmpW'(3)) begin
      oldest_d[fill_q[1:0]] = mv;
    end
  end

  // jump and drift tests
  assign need     = (trend_min_q < TminW'(TrendMinLow)) ? TminW'(TrendMinLow) : trend_min_q;
  assign jump_en  = fill_after >= CmpW'(JumpMinFill);
  assign drift_en = fill_after >= CmpW'(need);
  assign pair_sum = {1'b0, tap_q[1]} + {1'b0, tap_q[2]};
  assign jump     = $signed({2'b00, mv}) - $signed({2'b00, pair_sum[MvW:1]});
  assign new_sum  = {2'b00, mv} + {2'b00, tap_q[0]} + {2'b00, tap_q[1]};
  assign old_sum  = {2'b00, oldest_d[0]} + {2'b00, oldest_d[1]} + {2'b00, oldest_d[2]};
  assign new_avg  = div3(new_sum);
  assign old_avg  = div3(old_sum);
  assign drift    = $signed({2'b00, new_avg}) - $signed({2'b00, old_avg});
  assign flag_mid = jump_en ? apply_test(flag_q, jump, drop_th_q, rise_th_q) : flag_q;

  always_comb begin
    flag_d = flag_q;
    fill_d = fill_q;
    if (is_reading) begin
      flag_d = drift_en ? apply_test(flag_mid, drift, trend_th_q, trend_th_q) : flag_mid;
      fill_d = fill_after[FillW-1:0];
    end else begin
      fill_d = '0;
    end
  end

  assign res.source_changed    = flag_d ^ flag_q;
  assign res.on_external_power = flag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      flag_q <= 1'b1;
    end else if (s_acc) begin
      fill_q <= fill_d;
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && is_reading) begin
      tap_q[0] <= mv;
      for (int i = 1; i < Taps; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
      for (int i = 0; i < 3; i++) begin
        oldest_q[i] <= oldest_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_th_q   <= DropThresholdRst;
      rise_th_q   <= RiseThresholdRst;
      trend_th_q  <= TrendThresholdRst;
      trend_min_q <= TrendMinRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DROP_THRESHOLD:  drop_th_q   <= cfg_wdata_i;
        CFG_RISE_THRESHOLD:  rise_th_q   <= cfg_wdata_i;
        CFG_TREND_THRESHOLD: trend_th_q  <= cfg_wdata_i;
        CFG_TREND_MIN:       trend_min_q <= cfg_wdata_i[TminW-1:0];
      endcase
    end
  end

  svsd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (buf_ready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {6'b000000, out_res.on_external_power, out_res.source_changed};

`include "supply_voltage_source_detector_unit_assert.svh"

  `SVSD_ASSERT_ALWAYS(a_fill_bound, fill_q <= FillW'(WINDOW_DEPTH))
  `SVSD_ASSERT_NEXT(a_load_empties, s_acc && s_axis_tuser, fill_q == '0)
  `SVSD_ASSERT_NEXT(a_flag_hold, !s_acc, $stable(flag_q) && $stable(fill_q))

endmodule

>>> design/svsd_out_buf.sv
// ----------------------------------------------------------------------------
// svsd_out_buf
// two-entry result buffer: output register plus skid stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svsd_out_buf import svsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  res_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic main_valid_q, main_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t main_q, main_d;
  res_t skid_q, skid_d;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!main_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = in_data_i;
        main_valid_d = in_valid_i;
      end
    end else if (in_valid_i && !skid_valid_q) begin
      skid_d       = in_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule
